@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL of the date/time text parser.
// No dependencies; included by the files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When ante holds at a clock edge, cons must hold at the same edge.
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cond must never hold outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

@@ src/wdtp_pkg.sv @@
// Types, character codes and small decode functions of the date/time text parser.
// No dependencies; imported by wildcard_datetime_text_parser.
`default_nettype none

package wdtp_pkg;

    // Position within "YYYY-MM-DD W HH:MM:SS"
    typedef enum logic [3:0] {
        PH_YEAR   = 4'd0,
        PH_DASH1  = 4'd1,
        PH_MONTH  = 4'd2,
        PH_DASH2  = 4'd3,
        PH_DAY    = 4'd4,
        PH_WDAY   = 4'd5,
        PH_HOUR   = 4'd6,
        PH_COLON1 = 4'd7,
        PH_MIN    = 4'd8,
        PH_COLON2 = 4'd9,
        PH_SEC    = 4'd10
    } t_phase;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef struct packed {
        t_phase      phase;
        logic [2:0]  tlen;
        logic [13:0] tnum;
        logic        digits;
        logic        stars;
        logic [14:0] year;
        logic [7:0]  month;
        logic [7:0]  day;
        logic [4:0]  wday;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second;
        logic        failed;
        logic        finished;
    } t_parse_state;

    localparam t_parse_state CLEAR_STATE = '{
        phase:  PH_YEAR,
        digits: 1'b1,
        stars:  1'b1,
        default: '0
    };

    function automatic logic [2:0] tok_width(input t_phase p);
        logic [2:0] w;
        case (p)
            PH_YEAR:                                  w = 3'd4;
            PH_MONTH, PH_DAY, PH_HOUR, PH_MIN, PH_SEC: w = 3'd2;
            PH_WDAY:                                  w = 3'd1;
            default:                                  w = 3'd0;
        endcase
        return w;
    endfunction

    function automatic logic is_literal(input t_phase p);
        return (p == PH_DASH1) || (p == PH_DASH2) || (p == PH_COLON1) || (p == PH_COLON2);
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
    endfunction

endpackage

`default_nettype wire

@@ src/wildcard_datetime_text_parser.sv @@
// Streaming parser for "YYYY-MM-DD W HH:MM:SS" text, one character per request.
// Depends on wdtp_pkg and assert_macros.svh.
//
// Takes one character per clock, except while a last character waits for a held
// result, and returns one result per string, on the request that carries last.
// Each request passes through an input register, then a combinational update of
// the token state, and a result lands in the output register. The single
// per-character state update (one x10 add on a 14-bit accumulator) sets that rate.
// The output register lets characters without last keep flowing while a result
// waits; a last character waits in the input register only while the previous
// result is still held. The user must write allow_wildcards (r_allow) through
// i_cfg_we/i_cfg_wdata only while idle; the block itself does not enforce this.
`default_nettype none
`include "assert_macros.svh"

module wildcard_datetime_text_parser
    import wdtp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_wdata,
    input  wire logic               i_valid,
    output      logic               o_ready,
    input  wire logic [7:0]         i_ch,
    input  wire logic               i_last,
    output      logic               o_valid,
    input  wire logic               i_ready,
    output      logic               o_ok,
    output      logic signed [14:0] o_year,
    output      logic signed [7:0]  o_month,
    output      logic signed [7:0]  o_day,
    output      logic signed [4:0]  o_weekday,
    output      logic signed [7:0]  o_hour,
    output      logic signed [7:0]  o_minute,
    output      logic signed [7:0]  o_second
);

    function automatic t_parse_state finish_token(input t_parse_state s, input logic allow);
        t_parse_state r;
        logic         wild;
        r    = s;
        wild = s.stars && (s.tlen == tok_width(s.phase));
        if (wild && !allow) begin
            r.failed = 1'b1;
        end else if (wild || s.digits) begin
            case (s.phase)
                PH_YEAR:  r.year   = wild ? '1 : {1'b0, s.tnum};
                PH_MONTH: r.month  = wild ? '1 : s.tnum[7:0];
                PH_DAY:   r.day    = wild ? '1 : s.tnum[7:0];
                PH_WDAY:  r.wday   = wild ? '1 : s.tnum[4:0];
                PH_HOUR:  r.hour   = wild ? '1 : s.tnum[7:0];
                PH_MIN:   r.minute = wild ? '1 : s.tnum[7:0];
                PH_SEC:   r.second = wild ? '1 : s.tnum[7:0];
                default: ;
            endcase
            r.tlen   = '0;
            r.tnum   = '0;
            r.digits = 1'b1;
            r.stars  = 1'b1;
            if (s.phase >= PH_SEC) begin
                r.finished = 1'b1;
            end else begin
                r.phase = t_phase'(4'(s.phase + 4'd1));
            end
        end else begin
            r.failed = 1'b1;
        end
        return r;
    endfunction

    function automatic t_parse_state end_input(input t_parse_state s, input logic allow);
        t_parse_state r;
        r = s;
        if (s.phase == PH_SEC && s.tlen != 3'd0) begin
            r = finish_token(s, allow);
        end
        if (!r.finished) begin
            r.failed = 1'b1;
        end
        return r;
    endfunction

    logic         r_allow;
    logic         r_in_valid;
    logic [7:0]   r_in_ch;
    logic         r_in_last;
    t_parse_state r_state;
    t_parse_state n_state;
    t_parse_state s_done;
    logic         n_ok;
    logic         w_go;

    logic         r_out_valid;
    logic         r_out_ok;
    logic [14:0]  r_out_year;
    logic [7:0]   r_out_month;
    logic [7:0]   r_out_day;
    logic [4:0]   r_out_wday;
    logic [7:0]   r_out_hour;
    logic [7:0]   r_out_minute;
    logic [7:0]   r_out_second;

    // Advance the parser unless a last character would overwrite a held result
    assign w_go    = r_in_valid && (!r_in_last || !r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_go;

    always_comb begin
        t_parse_state s;
        s = r_state;
        if (!s.finished && !s.failed) begin
            if (r_in_ch == CH_NUL) begin
                s = end_input(s, r_allow);
            end else if (s.phase > PH_SEC) begin
                s.failed = 1'b1;
            end else if (is_literal(s.phase)) begin
                if (r_in_ch == ((s.phase < PH_DAY) ? CH_DASH : CH_COLON)) begin
                    s.phase = t_phase'(4'(s.phase + 4'd1));
                end else begin
                    s.failed = 1'b1;
                end
            end else if (is_ws(r_in_ch)) begin
                if (s.tlen != 3'd0) begin
                    s = finish_token(s, r_allow);
                    // a separator must follow directly, not after whitespace
                    if (!s.failed && !s.finished && is_literal(s.phase)) begin
                        s.failed = 1'b1;
                    end
                end
            end else begin
                if (r_in_ch inside {[CH_ZERO:CH_NINE]}) begin
                    s.stars = 1'b0;
                    s.tnum  = (s.tnum << 3) + (s.tnum << 1) + 14'(r_in_ch[3:0]);
                end else if (r_in_ch == CH_STAR) begin
                    s.digits = 1'b0;
                end else begin
                    s.digits = 1'b0;
                    s.stars  = 1'b0;
                end
                s.tlen = s.tlen + 3'd1;
                if (s.tlen >= tok_width(s.phase)) begin
                    s = finish_token(s, r_allow);
                end
            end
        end
        if (r_in_last && !s.finished && !s.failed) begin
            s = end_input(s, r_allow);
        end
        s_done  = s;
        n_ok    = s.finished && !s.failed;
        n_state = r_in_last ? CLEAR_STATE : s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow     <= 1'b0;
            r_in_valid  <= 1'b0;
            r_state     <= CLEAR_STATE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_allow <= i_cfg_wdata;
            end
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_go) begin
                r_state <= n_state;
            end
            if (w_go && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_ch   <= i_ch;
            r_in_last <= i_last;
        end
        if (w_go && r_in_last) begin
            r_out_ok     <= n_ok;
            // drop all values on failure
            r_out_year   <= n_ok ? s_done.year   : '0;
            r_out_month  <= n_ok ? s_done.month  : '0;
            r_out_day    <= n_ok ? s_done.day    : '0;
            r_out_wday   <= n_ok ? s_done.wday   : '0;
            r_out_hour   <= n_ok ? s_done.hour   : '0;
            r_out_minute <= n_ok ? s_done.minute : '0;
            r_out_second <= n_ok ? s_done.second : '0;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_ok      = r_out_ok;
    assign o_year    = $signed(r_out_year);
    assign o_month   = $signed(r_out_month);
    assign o_day     = $signed(r_out_day);
    assign o_weekday = $signed(r_out_wday);
    assign o_hour    = $signed(r_out_hour);
    assign o_minute  = $signed(r_out_minute);
    assign o_second  = $signed(r_out_second);

    `ASSERT_IMPLIES(a_fail_zero, i_clk, i_rst_n, o_valid && !o_ok,
        o_year == 0 && o_month == 0 && o_day == 0 && o_weekday == 0 &&
        o_hour == 0 && o_minute == 0 && o_second == 0,
        "failed result carries nonzero field")
    `ASSERT_NEVER(a_fail_and_done, i_clk, i_rst_n, r_state.failed && r_state.finished,
        "parser both failed and finished")
    `ASSERT_IMPLIES(a_done_phase, i_clk, i_rst_n, r_state.finished, r_state.phase == PH_SEC,
        "parser finished before the seconds token")
    `ASSERT_IMPLIES(a_tlen_range, i_clk, i_rst_n, r_state.tlen != 3'd0 && !r_state.failed,
        r_state.tlen < tok_width(r_state.phase), "token length reached its width unfinished")

endmodule

`default_nettype wire

@@ dv/tb_wildcard_datetime_text_parser.sv @@
// Testbench for wildcard_datetime_text_parser: directed and random strings, checked per result.
// Depends on wdtp_pkg (phase enum, character codes) and the parser RTL.
`timescale 1ns / 100ps

module tb_wildcard_datetime_text_parser;
    import wdtp_pkg::*;

    typedef struct {
        logic              ok;
        logic signed [14:0] year;
        logic signed [7:0]  month;
        logic signed [7:0]  day;
        logic signed [4:0]  weekday;
        logic signed [7:0]  hour;
        logic signed [7:0]  minute;
        logic signed [7:0]  second;
    } t_dt_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_wdata = 1'b0;
    logic               i_valid = 1'b0;
    logic [7:0]         i_ch = 8'h20;
    logic               i_last = 1'b0;
    logic               i_ready = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic               o_ok;
    logic signed [14:0] o_year;
    logic signed [7:0]  o_month;
    logic signed [7:0]  o_day;
    logic signed [4:0]  o_weekday;
    logic signed [7:0]  o_hour;
    logic signed [7:0]  o_minute;
    logic signed [7:0]  o_second;

    wildcard_datetime_text_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_ch        (i_ch),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_ok        (o_ok),
        .o_year      (o_year),
        .o_month     (o_month),
        .o_day       (o_day),
        .o_weekday   (o_weekday),
        .o_hour      (o_hour),
        .o_minute    (o_minute),
        .o_second    (o_second)
    );

    always #6 i_clk = ~i_clk;

    // Parser state mirrored by the predictor
    t_phase      dt_phase;
    logic [2:0]  tok_len;
    logic [13:0] tok_val;
    bit          tok_digits;
    bit          tok_stars;
    logic [15:0] field_val [7];
    bit          parse_failed;
    bit          parse_done;
    bit          wildcards_on;

    t_dt_result  pending_dt_q [$];
    t_dt_result  head_dt;
    logic [7:0]  text_q [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_cycles = 0;
    int n_chars = 0;
    int n_strings = 0;
    int n_results = 0;
    int n_ok_expected = 0;
    int n_wild_expected = 0;
    int n_errors = 0;

    // ---------------------------------------------------------------- predictor

    function automatic int unsigned width_of(t_phase p);
        case (p)
            PH_YEAR:                                   return 4;
            PH_MONTH, PH_DAY, PH_HOUR, PH_MIN, PH_SEC: return 2;
            PH_WDAY:                                   return 1;
            default:                                   return 0;
        endcase
    endfunction

    function automatic int unsigned slot_of(t_phase p);
        case (p)
            PH_MONTH: return 1;
            PH_DAY:   return 2;
            PH_WDAY:  return 3;
            PH_HOUR:  return 4;
            PH_MIN:   return 5;
            PH_SEC:   return 6;
            default:  return 0;
        endcase
    endfunction

    function automatic bit is_separator(t_phase p);
        return p == PH_DASH1 || p == PH_DASH2 || p == PH_COLON1 || p == PH_COLON2;
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic void clear_token();
        tok_len    = '0;
        tok_val    = '0;
        tok_digits = 1'b1;
        tok_stars  = 1'b1;
    endfunction

    function automatic void reset_parse();
        dt_phase = PH_YEAR;
        clear_token();
        foreach (field_val[i]) field_val[i] = '0;
        parse_failed = 1'b0;
        parse_done   = 1'b0;
    endfunction

    function automatic void close_token();
        if (tok_stars && tok_len == width_of(dt_phase)) begin
            if (!wildcards_on) begin
                parse_failed = 1'b1;
                return;
            end
            field_val[slot_of(dt_phase)] = 16'hFFFF;
        end else if (tok_digits) begin
            field_val[slot_of(dt_phase)] = {2'b00, tok_val};
        end else begin
            parse_failed = 1'b1;
            return;
        end
        clear_token();
        if (dt_phase == PH_SEC) parse_done = 1'b1;
        else dt_phase = t_phase'(dt_phase + 1);
    endfunction

    function automatic void end_of_text();
        if (dt_phase == PH_SEC && tok_len > 0) close_token();
        if (!parse_done) parse_failed = 1'b1;
    endfunction

    function automatic void consume_char(logic [7:0] c);
        int unsigned acc;
        logic [7:0]  want;
        if (parse_done || parse_failed) return;
        if (c == CH_NUL) begin
            end_of_text();
            return;
        end
        if (is_separator(dt_phase)) begin
            want = (dt_phase < PH_WDAY) ? CH_DASH : CH_COLON;
            if (c == want) dt_phase = t_phase'(dt_phase + 1);
            else parse_failed = 1'b1;
            return;
        end
        if (is_blank(c)) begin
            if (tok_len == 0) return;
            close_token();
            // a token cut short right before '-' or ':' cannot recover
            if (!parse_failed && !parse_done && is_separator(dt_phase)) parse_failed = 1'b1;
            return;
        end
        if (c >= CH_ZERO && c <= CH_NINE) begin
            tok_stars = 1'b0;
            acc = tok_val * 10 + (c - CH_ZERO);
            tok_val = acc[13:0];
        end else if (c == CH_STAR) begin
            tok_digits = 1'b0;
        end else begin
            tok_digits = 1'b0;
            tok_stars  = 1'b0;
        end
        tok_len = tok_len + 1'b1;
        if (tok_len >= width_of(dt_phase)) close_token();
    endfunction

    function automatic void predict_char(logic [7:0] c, bit is_last);
        t_dt_result r;
        consume_char(c);
        if (!is_last) return;
        if (!parse_done && !parse_failed) end_of_text();
        r = '{default: 0};
        if (parse_done && !parse_failed) begin
            r.ok      = 1'b1;
            r.year    = field_val[0][14:0];
            r.month   = field_val[1][7:0];
            r.day     = field_val[2][7:0];
            r.weekday = field_val[3][4:0];
            r.hour    = field_val[4][7:0];
            r.minute  = field_val[5][7:0];
            r.second  = field_val[6][7:0];
            n_ok_expected++;
            foreach (field_val[i])
                if (field_val[i] == 16'hFFFF) begin
                    n_wild_expected++;
                    break;
                end
        end
        pending_dt_q.push_back(r);
        n_strings++;
        reset_parse();
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic send_char(input logic [7:0] c, input bit is_last);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_ch    <= c;
        i_last  <= is_last;
        do @(posedge i_clk); while (!o_ready);
        predict_char(c, is_last);
        n_chars++;
    endtask

    task automatic send_text(input bit end_here);
        foreach (text_q[i]) send_char(text_q[i], end_here && i == text_q.size() - 1);
    endtask

    task automatic send_str(input string s, input bit end_here = 1'b1);
        text_q.delete();
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
        send_text(end_here);
    endtask

    // Write the register only once the pipeline has drained
    task automatic set_wildcards(input bit v);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_dt_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        wildcards_on = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            i_ready <= 1'b0;
            hold_off_cycles--;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH result %0d: %s got %0d want %0d", n_results, what, got, want);
        n_errors++;
    endtask

    task automatic check_field(input string name, input logic signed [31:0] got,
                               input logic signed [31:0] want);
        if (got !== want) report_mismatch(name, got, want);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_dt_q.size() == 0) begin
                report_mismatch("unexpected result, ok", o_ok, 0);
            end else begin
                head_dt = pending_dt_q.pop_front();
                check_field("ok", o_ok, head_dt.ok);
                check_field("year", o_year, head_dt.year);
                check_field("month", o_month, head_dt.month);
                check_field("day", o_day, head_dt.day);
                check_field("weekday", o_weekday, head_dt.weekday);
                check_field("hour", o_hour, head_dt.hour);
                check_field("minute", o_minute, head_dt.minute);
                check_field("second", o_second, head_dt.second);
            end
            n_results++;
        end
    end

    // ---------------------------------------------------------------- text generation

    function automatic logic [7:0] blank_char();
        int unsigned r;
        r = $urandom_range(7);
        return (r > 4) ? CH_SPACE : CH_TAB + 8'(r);
    endfunction

    function automatic logic [7:0] noisy_char();
        string charset;
        charset = "0123456789**-:: ";
        if ($urandom_range(1)) return charset[$urandom_range(charset.len() - 1)];
        return 8'($urandom_range(255, 1));
    endfunction

    function automatic void push_blanks(int unsigned max_len);
        repeat ($urandom_range(max_len)) text_q.push_back(blank_char());
    endfunction

    function automatic void push_token(int unsigned width, bit wild, bit may_short);
        int unsigned n;
        n = (may_short && !wild && $urandom_range(3) == 0) ? 1 : width;
        repeat (n) text_q.push_back(wild ? CH_STAR : CH_ZERO + 8'($urandom_range(9)));
    endfunction

    // Well-formed text with random digits, optional stars, short tokens, whitespace and trailing noise
    function automatic void build_datetime();
        int unsigned tok_w [7];
        bit          use_stars;
        tok_w = '{4, 2, 2, 1, 2, 2, 2};
        use_stars = ($urandom_range(2) == 0);
        text_q.delete();
        for (int k = 0; k < 7; k++) begin
            if ($urandom_range(3) == 0) push_blanks(2);
            push_token(tok_w[k], use_stars && $urandom_range(2) == 0, k == 2 || k == 6);
            case (k)
                0, 1: text_q.push_back(CH_DASH);
                2, 3: begin
                    if ($urandom_range(7) != 0) text_q.push_back(blank_char());
                    push_blanks(1);
                end
                4, 5: text_q.push_back(CH_COLON);
                default: begin
                    if ($urandom_range(4) == 0) begin
                        text_q.push_back(blank_char());
                        repeat ($urandom_range(4, 1)) text_q.push_back(noisy_char());
                    end
                end
            endcase
        end
    endfunction

    function automatic void break_text();
        int unsigned pos;
        int unsigned keep;
        pos = $urandom_range(text_q.size() - 1);
        case ($urandom_range(2))
            0: text_q[pos] = 8'($urandom_range(255, 1));
            1: begin
                keep = $urandom_range(text_q.size() - 1, 1);
                while (text_q.size() > keep) void'(text_q.pop_back());
            end
            default: text_q.insert(pos, noisy_char());
        endcase
    endfunction

    function automatic void build_noise();
        text_q.delete();
        repeat ($urandom_range(24, 1)) text_q.push_back(noisy_char());
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_plain_formats();
        set_wildcards(1'b0);
        send_str("2024-01-15 3 12:34:56");
        send_str("9999-99-99 9 99:99:99");
        send_str("0000-00-00 0 00:00:00");
        send_str("\t 2024-\t01- 15\t\t3  12:\n34: 56");
        send_str("2024-01-5 3 08:07:5");
        send_str("2024-01-15312:34:56");
        send_str("2024-01-15 3 12:34:56 trailing text");
    endtask

    task automatic test_wildcard_fields();
        set_wildcards(1'b1);
        send_str("****-**-** * **:**:**");
        send_str("2024-**-15 * 12:**:56");
        set_wildcards(1'b0);
        send_str("****-**-** * **:**:**");
        send_str("2024-01-15 * 12:34:56");
    endtask

    task automatic test_malformed();
        logic [7:0] tail [$];
        set_wildcards(1'b1);
        send_str("***-01-15 3 12:34:56");
        send_str("2*24-01-15 3 12:34:56");
        send_str("20a4-01-15 3 12:34:56");
        send_str("2024/01-15 3 12:34:56");
        send_str("2024-1-15 3 12:34:56");
        send_str("2024-01-15 3 12:34:");
        send_str("7");
        send_str("2x24-01-15 3 12:34:56 more 99");
        // a NUL ends the text early; what follows is dropped
        send_str("2024-01-15 3 12:34:5", 1'b0);
        tail = '{CH_NUL, "x", "y"};
        text_q = tail;
        send_text(1'b1);
    endtask

    task automatic test_wildcard_timing();
        // stars are judged against the setting in force when the token closes
        set_wildcards(1'b0);
        send_str("***", 1'b0);
        set_wildcards(1'b1);
        send_str("*-**-** * **:**:**");
        send_str("***", 1'b0);
        set_wildcards(1'b0);
        send_str("*-01-15 3 12:34:56");
    endtask

    task automatic test_backpressure();
        set_wildcards(1'b1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge i_clk);
        hold_off_cycles = 200;
        repeat (4) send_str("2024-01-15 3 12:34:56");
    endtask

    task automatic test_random_mix();
        int unsigned target;
        int unsigned kind;
        for (int m = 0; m < 8; m++) begin
            set_wildcards(m[0]);
            case (m >> 1)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            target = n_chars + 90;
            while (n_chars < target) begin
                kind = $urandom_range(99);
                if (kind < 85) begin
                    build_datetime();
                    if (kind >= 65) break_text();
                end else begin
                    build_noise();
                end
                send_text(1'b1);
            end
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        wildcards_on = 1'b0;
        reset_parse();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_plain_formats();
        test_wildcard_fields();
        test_malformed();
        test_wildcard_timing();
        test_backpressure();
        test_random_mix();

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_dt_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d characters in %0d strings; %0d results checked", n_chars,
                 n_strings, n_results);
        $display("Expected %0d successful parses, %0d of them with wildcard fields",
                 n_ok_expected, n_wild_expected);
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", pending_dt_q.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
